@@ hw/rtl/tksl_pkg.sv @@
// shared types and constants for the scan list merge block
package tksl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int NAME_WORDS = 4;
    localparam int NAME_W     = 256;
    localparam int STR_W      = 8;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int CMD_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_MERGE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_DECIDE,
        ST_TAIL_RD,
        ST_TAIL,
        ST_SORT_RD,
        ST_SORT,
        ST_WRITE,
        ST_READ_RD,
        ST_READ,
        ST_DONE
    } state_t;

    localparam logic [0:0] ADDR_CAPACITY = 1'b0;

endpackage

@@ hw/rtl/top_k_scan_list_merge_core.sv @@
// scan list merge block top level
// command transactions: start with command and payload while busy is low;
// one result per transaction is shown for one cycle with done high.
// clear, and command 3, go straight to the done state; read passes through
// a memory read state and a result state. merge scans the list one entry at a
// time through the single memory read port (read then compare), then moves the
// new entry up by shifting weaker entries down one slot at a time (read then
// write). a merge is dropped at once, straight to the done state, when the
// name is empty, the capacity is zero or the count is above the capacity.
// busy stays high from acceptance until the done cycle, in which a new
// transaction may already be accepted.
// the receiver cannot stall; results are not held.
// reset clears the count and sets capacity to the maximum; entry contents
// are undefined until written and never returned past the count.
// the user must write capacity over the apb port only while idle; the block does not check.
module top_k_scan_list_merge_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [63:0] ssid_word0,
    input  logic [63:0] ssid_word1,
    input  logic [63:0] ssid_word2,
    input  logic [63:0] ssid_word3,
    input  logic signed [7:0] strength,
    input  logic        is_secure,
    input  logic [3:0]  read_index,
    output logic        done,
    output logic [4:0]  entry_count,
    output logic        accepted,
    output logic        entry_valid,
    output logic [63:0] out_ssid_word0,
    output logic [63:0] out_ssid_word1,
    output logic [63:0] out_ssid_word2,
    output logic [63:0] out_ssid_word3,
    output logic signed [7:0] out_strength,
    output logic        out_secure
);
    import tksl_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    state_t state_reg, state_next;
    logic [4:0] cap_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] dest_reg;
    logic [NAME_W-1:0] cname_reg;
    logic signed [STR_W-1:0] cstr_reg;
    logic csec_reg, found_reg, acc_reg;
    logic [1:0] cmd_reg;
    logic [IDX_W-1:0] ridx_reg;

    logic mwe;
    logic [AW-1:0] mwaddr, mraddr;
    logic [NAME_W-1:0] mwname, rname;
    logic [STR_W-1:0] mwstr, rstr;
    logic mwsec, rsec;

    tksl_entry_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
        .clk(clk), .we(mwe), .waddr(mwaddr), .wname(mwname), .wstr(mwstr),
        .wsec(mwsec), .raddr(mraddr), .rname(rname), .rstr(rstr), .rsec(rsec)
    );

    // name normalization
    logic [NAME_W-1:0] in_raw, in_norm;
    logic ended;
    always_comb
    begin
        in_raw = {ssid_word3, ssid_word2, ssid_word1, ssid_word0};
        in_norm = '0;
        ended = 1'b0;
        for (int i = 0; i < 32; i++)
        begin
            if (in_raw[i*8 +: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                in_norm[i*8 +: 8] = in_raw[i*8 +: 8];
            end
        end
    end

    logic [CW-1:0] cap_eff;
    always_comb
    begin
        if ({1'b0, cap_reg} > 6'(MAX_ENTRIES))
        begin
            cap_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    logic go;
    assign go = start && !busy;
    assign busy = (state_reg != ST_IDLE);
    assign pready = 1'b1;
    assign prdata = {27'd0, cap_reg};

    logic rd_match, rd_weaker, read_ok;
    assign rd_match  = (rname == cname_reg);
    assign rd_weaker = ($signed(rstr) < cstr_reg);
    assign read_ok   = ({1'b0, ridx_reg} < (IDX_W+1)'(count_reg))
                       && ({1'b0, ridx_reg} < (IDX_W+1)'(MAX_ENTRIES));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    unique case (cmd_t'(command))
                        CMD_MERGE:
                        begin
                            if (cap_eff == '0 || count_reg > cap_eff || in_norm == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = ST_DECIDE;
                            end
                            else
                            begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        CMD_READ:  state_next = ST_READ_RD;
                        CMD_CLEAR, CMD_NONE: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (rd_match || ptr_reg + 1'b1 == count_reg)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DECIDE:
            begin
                if (found_reg)
                begin
                    if (!acc_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = (dest_reg == '0) ? ST_WRITE : ST_SORT_RD;
                    end
                end
                else if (count_reg < cap_eff)
                begin
                    state_next = (dest_reg == '0) ? ST_WRITE : ST_SORT_RD;
                end
                else
                begin
                    state_next = ST_TAIL_RD;
                end
            end
            ST_TAIL_RD: state_next = ST_TAIL;
            ST_TAIL:
            begin
                if (rd_weaker)
                begin
                    state_next = (dest_reg == '0) ? ST_WRITE : ST_SORT_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SORT_RD: state_next = ST_SORT;
            ST_SORT:
            begin
                if (rd_weaker && dest_reg > CW'(1))
                begin
                    state_next = ST_SORT_RD;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:   state_next = ST_DONE;
            ST_READ_RD: state_next = ST_READ;
            ST_READ:    state_next = ST_IDLE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        mwe = 1'b0;
        mwaddr = dest_reg[AW-1:0];
        mwname = cname_reg;
        mwstr = cstr_reg;
        mwsec = csec_reg;
        mraddr = ptr_reg[AW-1:0];
        unique case (state_reg)
            ST_SORT:
            begin
                if (rd_weaker)
                begin
                    mwe = 1'b1;
                    mwname = rname;
                    mwstr = rstr;
                    mwsec = rsec;
                end
            end
            ST_WRITE: mwe = 1'b1;
            ST_READ_RD: mraddr = ridx_reg[AW-1:0];
            ST_SORT_RD: mraddr = AW'(dest_reg - 1'b1);
            ST_TAIL_RD: mraddr = dest_reg[AW-1:0];
            default: mwe = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= 5'd16;
            count_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done <= (state_reg == ST_DONE) || (state_reg == ST_READ);
            if (psel && penable && pwrite && paddr[2] == ADDR_CAPACITY)
            begin
                cap_reg <= pwdata[4:0];
            end
            if (go && cmd_t'(command) == CMD_CLEAR)
            begin
                count_reg <= '0;
            end
            if (state_reg == ST_DECIDE && !found_reg && count_reg < cap_eff)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cname_reg <= in_norm;
                cstr_reg  <= strength;
                csec_reg  <= is_secure;
                cmd_reg   <= command;
                ridx_reg  <= read_index;
                ptr_reg   <= '0;
                found_reg <= 1'b0;
                acc_reg   <= 1'b0;
                dest_reg  <= count_reg;
            end
            ST_SCAN:
            begin
                if (rd_match)
                begin
                    found_reg <= 1'b1;
                    dest_reg  <= ptr_reg;
                    acc_reg   <= rd_weaker;
                end
                ptr_reg <= ptr_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                if (!found_reg)
                begin
                    acc_reg <= (count_reg < cap_eff);
                    if (count_reg >= cap_eff)
                    begin
                        dest_reg <= count_reg - 1'b1;
                    end
                end
            end
            ST_TAIL:
            begin
                acc_reg <= rd_weaker;
                dest_reg <= count_reg - 1'b1;
            end
            ST_SORT:
            begin
                if (rd_weaker)
                begin
                    dest_reg <= dest_reg - 1'b1;
                end
            end
            default:
            begin
                cmd_reg <= cmd_reg;
            end
        endcase
    end

    // tail: the weakest entry at dest was read and is the slot replaced
    // result registers
    always_ff @(posedge clk)
    begin
        entry_count    <= 5'(count_reg);
        accepted       <= 1'b0;
        entry_valid    <= 1'b0;
        out_ssid_word0 <= '0;
        out_ssid_word1 <= '0;
        out_ssid_word2 <= '0;
        out_ssid_word3 <= '0;
        out_strength   <= '0;
        out_secure     <= 1'b0;
        if (state_reg == ST_DONE)
        begin
            accepted <= acc_reg && (cmd_t'(cmd_reg) == CMD_MERGE);
        end
        if (state_reg == ST_READ && read_ok)
        begin
            entry_valid    <= 1'b1;
            out_ssid_word0 <= rname[63:0];
            out_ssid_word1 <= rname[127:64];
            out_ssid_word2 <= rname[191:128];
            out_ssid_word3 <= rname[255:192];
            out_strength   <= rstr;
            out_secure     <= rsec;
        end
    end
endmodule

@@ hw/rtl/tksl_entry_mem.sv @@
// entry storage: name, strength and secure flag, one synchronous read port
module tksl_entry_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [tksl_pkg::NAME_W-1:0] wname,
    input  logic [tksl_pkg::STR_W-1:0]  wstr,
    input  logic                     wsec,
    input  logic [AW-1:0]            raddr,
    output logic [tksl_pkg::NAME_W-1:0] rname,
    output logic [tksl_pkg::STR_W-1:0]  rstr,
    output logic                     rsec
);
    import tksl_pkg::*;

    logic [NAME_W+STR_W:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wsec, wstr, wname};
        end
        {rsec, rstr, rname} <= mem[raddr];
    end
endmodule

@@ tb/top_k_scan_list_merge_checker.sv @@
`timescale 1ns / 100ps
// scan list checker: predicts each command transaction and compares the results
module top_k_scan_list_merge_checker
    import tksl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  command,
    input  logic [63:0] ssid_word0,
    input  logic [63:0] ssid_word1,
    input  logic [63:0] ssid_word2,
    input  logic [63:0] ssid_word3,
    input  logic signed [7:0] strength,
    input  logic        is_secure,
    input  logic [3:0]  read_index,
    input  logic        done,
    input  logic [4:0]  entry_count,
    input  logic        accepted,
    input  logic        entry_valid,
    input  logic [63:0] out_ssid_word0,
    input  logic [63:0] out_ssid_word1,
    input  logic [63:0] out_ssid_word2,
    input  logic [63:0] out_ssid_word3,
    input  logic signed [7:0] out_strength,
    input  logic        out_secure,
    output int          fail_count,
    output int          pending
);

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              acc;
        logic              valid;
        logic [NAME_W-1:0] name;
        logic [STR_W-1:0]  str;
        logic              sec;
    } scan_result_t;

    scan_result_t      expected_results[$];
    logic [NAME_W-1:0] list_name[SLOTS];
    logic signed [7:0] list_str[SLOTS];
    logic              list_sec[SLOTS];
    int                held;
    int                capacity;

    assign pending = expected_results.size();

    function automatic logic [NAME_W-1:0] clean_name(logic [NAME_W-1:0] raw, output int len);
        logic [NAME_W-1:0] nm;
        bit                ended;
        nm    = '0;
        ended = 0;
        len   = 0;
        for (int i = 0; i < 32; i++) begin
            if (raw[8*i +: 8] == 8'd0)
                ended = 1;
            if (!ended) begin
                nm[8*i +: 8] = raw[8*i +: 8];
                len++;
            end
        end
        return nm;
    endfunction

    function automatic void sort_by_strength();
        logic [NAME_W-1:0] nm;
        logic signed [7:0] st;
        logic              sc;
        int                pos;
        for (int i = 1; i < held; i++) begin
            nm  = list_name[i];
            st  = list_str[i];
            sc  = list_sec[i];
            pos = i;
            while (pos > 0 && list_str[pos-1] < st) begin
                list_name[pos] = list_name[pos-1];
                list_str[pos]  = list_str[pos-1];
                list_sec[pos]  = list_sec[pos-1];
                pos--;
            end
            list_name[pos] = nm;
            list_str[pos]  = st;
            list_sec[pos]  = sc;
        end
    endfunction

    function automatic bit merge_candidate(logic [NAME_W-1:0] raw, logic signed [7:0] st,
                                           logic sec);
        logic [NAME_W-1:0] nm;
        int                len;
        int                cap;
        int                dest;
        cap = capacity > SLOTS ? SLOTS : capacity;
        if (cap == 0 || held > cap)
            return 0;
        nm = clean_name(raw, len);
        if (len == 0)
            return 0;
        dest = held;
        for (int i = 0; i < held; i++) begin
            if (list_name[i] == nm) begin
                if (st <= list_str[i])
                    return 0;
                dest = i;
                break;
            end
        end
        if (dest == held) begin
            if (held < cap) begin
                held++;
            end else begin
                dest = held - 1;
                if (st <= list_str[dest])
                    return 0;
            end
        end
        list_name[dest] = nm;
        list_str[dest]  = st;
        list_sec[dest]  = sec;
        sort_by_strength();
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        scan_result_t exp_r;
        scan_result_t act_r;
        if (!rst_n) begin
            held     = 0;
            capacity = SLOTS;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'(ADDR_CAPACITY) * 3'd4)
                capacity = int'(pwdata[4:0]);
            if (start && !busy) begin
                exp_r = '0;
                case (cmd_t'(command))
                    CMD_CLEAR: held = 0;
                    CMD_MERGE: exp_r.acc = merge_candidate(
                        {ssid_word3, ssid_word2, ssid_word1, ssid_word0}, strength, is_secure);
                    CMD_READ: begin
                        if (int'(read_index) < held) begin
                            exp_r.valid = 1;
                            exp_r.name  = list_name[read_index];
                            exp_r.str   = list_str[read_index];
                            exp_r.sec   = list_sec[read_index];
                        end
                    end
                    default: ;
                endcase
                exp_r.count = CNT_W'(held);
                expected_results.push_back(exp_r);
            end
            if (done) begin
                act_r = {entry_count, accepted, entry_valid, out_ssid_word3, out_ssid_word2,
                         out_ssid_word1, out_ssid_word0, out_strength, out_secure};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with no transaction pending", $realtime);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (act_r.count !== exp_r.count || act_r.acc !== exp_r.acc ||
                        act_r.valid !== exp_r.valid || act_r.name !== exp_r.name ||
                        act_r.str !== exp_r.str || act_r.sec !== exp_r.sec) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch count %0d/%0d acc %0b/%0b valid %0b/%0b str %0d/%0d sec %0b/%0b\n  name exp %h\n  name act %h",
                                     $realtime, exp_r.count, act_r.count, exp_r.acc, act_r.acc,
                                     exp_r.valid, act_r.valid, $signed(exp_r.str),
                                     $signed(act_r.str), exp_r.sec, act_r.sec,
                                     exp_r.name, act_r.name);
                    end
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

@@ tb/top_k_scan_list_merge_core_tb.sv @@
`timescale 1ns / 100ps
// testbench top: stimulus, capacity phases and verdict for the scan list block
module top_k_scan_list_merge_core_tb;
    import tksl_pkg::*;

    localparam int POOL      = 24;
    localparam int IDLE_LIMIT = 5000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 0;
    logic        busy;
    logic [1:0]  command = CMD_CLEAR;
    logic [63:0] ssid_word0 = '0;
    logic [63:0] ssid_word1 = '0;
    logic [63:0] ssid_word2 = '0;
    logic [63:0] ssid_word3 = '0;
    logic signed [7:0] strength = '0;
    logic        is_secure = 0;
    logic [3:0]  read_index = '0;
    logic        done;
    logic [4:0]  entry_count;
    logic        accepted;
    logic        entry_valid;
    logic [63:0] out_ssid_word0, out_ssid_word1, out_ssid_word2, out_ssid_word3;
    logic signed [7:0] out_strength;
    logic        out_secure;
    int          fail_count;
    int          pending;

    logic [7:0]  pool_bytes[POOL][32];
    int          pool_len[POOL];
    int          sent_items;
    int          merges_sent;
    int          idle_cycles;

    always #5 clk = ~clk;

    top_k_scan_list_merge_core u_top (.*);

    top_k_scan_list_merge_checker u_checker (.*);

    always @(posedge clk) begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d transactions outstanding", pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_capacity(int value);
        @(posedge clk);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= 3'(ADDR_CAPACITY) * 3'd4;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic drain();
        @(posedge clk);
        start <= 0;
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send(cmd_t cmd, int pidx, bit junk_tail, int str, bit sec, int idx);
        logic [255:0] nm;
        int           gap;
        nm = '0;
        for (int i = 0; i < 32; i++) begin
            if (i < pool_len[pidx])
                nm[8*i +: 8] = pool_bytes[pidx][i];
            else if (i > pool_len[pidx] && junk_tail)
                nm[8*i +: 8] = 8'($urandom_range(0, 255));
        end
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1;
        command    <= cmd;
        {ssid_word3, ssid_word2, ssid_word1, ssid_word0} <= nm;
        strength   <= 8'(str);
        is_secure  <= sec;
        read_index <= 4'(idx);
        do @(posedge clk); while (busy);
        sent_items++;
        if (cmd == CMD_MERGE)
            merges_sent++;
    endtask

    task automatic merge_item(int pidx, int str, bit sec);
        send(CMD_MERGE, pidx, $urandom_range(0, 1), str, sec, $urandom_range(0, 15));
    endtask

    task automatic random_items(int n, int names);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 62)
                merge_item($urandom_range(0, names - 1), $urandom_range(0, 255),
                           $urandom_range(0, 1));
            else if (r < 92)
                send(CMD_READ, $urandom_range(0, POOL - 1), 1, $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 15));
            else if (r < 95)
                send(CMD_CLEAR, $urandom_range(0, POOL - 1), 1, $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 15));
            else
                send(CMD_NONE, $urandom_range(0, POOL - 1), 1, $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 15));
        end
    endtask

    initial begin
        int caps[6];
        caps = '{16, 1, 31, 5, 0, 12};
        sent_items  = 0;
        merges_sent = 0;
        idle_cycles = 0;
        // pool: entry 0 empty, entry 1 full length, the rest random lengths
        for (int p = 0; p < POOL; p++) begin
            pool_len[p] = p == 0 ? 0 : p == 1 ? 32 : $urandom_range(1, 31);
            for (int i = 0; i < 32; i++)
                pool_bytes[p][i] = 8'($urandom_range(1, 255));
        end
        repeat (6) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed
        write_capacity(3);
        merge_item(0, 50, 1);
        merge_item(1, 127, 1);
        merge_item(2, -128, 0);
        merge_item(3, 10, 0);
        merge_item(4, 10, 1);
        merge_item(3, 10, 1);
        merge_item(3, 9, 1);
        merge_item(3, 20, 0);
        merge_item(5, -128, 1);
        merge_item(5, 11, 1);
        for (int i = 0; i < 4; i++)
            send(CMD_READ, 0, 0, 0, 0, i);
        send(CMD_READ, 0, 0, 0, 0, 15);
        send(CMD_NONE, 1, 1, -1, 1, 15);
        drain();
        write_capacity(2);
        merge_item(6, 127, 1);
        send(CMD_READ, 0, 0, 0, 0, 0);
        send(CMD_CLEAR, 0, 0, 0, 0, 0);
        merge_item(6, 1, 0);
        drain();
        write_capacity(0);
        merge_item(7, 5, 1);
        send(CMD_READ, 0, 0, 0, 0, 0);
        drain();

        // random phases at several capacities
        foreach (caps[c]) begin
            write_capacity(caps[c]);
            send(CMD_CLEAR, 0, 0, 0, 0, 0);
            random_items(190, c % 2 == 0 ? POOL : 10);
            drain();
        end

        // capacity lowered under the count: merges ignored until a clear
        write_capacity(16);
        for (int p = 1; p < POOL; p++)
            merge_item(p, $urandom_range(0, 255), $urandom_range(0, 1));
        drain();
        write_capacity(4);
        random_items(40, POOL);
        drain();

        // sender waits for every result before each transaction
        write_capacity(16);
        for (int k = 0; k < 40; k++) begin
            random_items(1, POOL);
            drain();
        end
        drain();
        repeat (60) @(posedge clk);

        $display("%0d transactions, %0d merges; capacities 0,1,2,3,4,5,12,16,31 and lowered count",
                 sent_items, merges_sent);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
